// ===== src/sdbt_pkg.sv =====
// shared types, constants and helpers of the stage dependency bubble tracker
// no dependencies; imported by every module of the block but sdbt_ram
`default_nettype none

package sdbt_pkg;

    localparam int NUM_STAGES    = 4;
    localparam int COUNT_BITS    = 32;
    localparam int MASK_BITS     = 4;
    localparam int MASK_IDX_BITS = $clog2(MASK_BITS);
    localparam int STAGE_BITS    = $clog2(NUM_STAGES);
    localparam int ENTRIES       = NUM_STAGES * NUM_STAGES;
    localparam int ENTRY_BITS    = $clog2(ENTRIES);
    localparam int PAIR_BITS     = 2 * COUNT_BITS;

    typedef logic [STAGE_BITS-1:0] stage_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ENTRY_BITS-1:0] entry_idx_t;
    typedef logic [MASK_BITS-1:0]  mask_t;

    localparam stage_idx_t STAGE_COMPUTE  = stage_idx_t'(0);
    localparam stage_idx_t STAGE_GEOMETRY = stage_idx_t'(1);
    localparam stage_idx_t STAGE_LAST     = stage_idx_t'(NUM_STAGES - 1);
    localparam count_t     COUNT_MAX      = '1;

    typedef enum logic
    {
        OP_WORK    = 1'b0,
        OP_BARRIER = 1'b1
    } op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SUB_INIT,
        ST_SUB_RD_FWD,
        ST_SUB_RD_REV,
        ST_SUB_EVAL,
        ST_SUB_INC,
        ST_BAR_DST,
        ST_BAR_SRC,
        ST_BAR_OWN_RD,
        ST_BAR_OWN_WR,
        ST_BAR_K_RD_SRC,
        ST_BAR_K_RD_DST,
        ST_BAR_K_WR,
        ST_DONE
    } state_t;

    // read address forms: a is target row, b the other stage, k the merged column
    typedef enum logic [1:0]
    {
        RD_AB,
        RD_BA,
        RD_BK,
        RD_AK
    } rd_sel_t;

    typedef struct packed
    {
        logic    load_item;
        logic    cap_dst;
        logic    cap_oth;
        logic    cap_src;
        rd_sel_t rd_sel;
        logic    cond_chk;
        logic    mask_chk;
        logic    wr_own;
        logic    wr_inh;
        logic    inc_a;
        logic    inc_b;
        logic    clr_b;
        logic    inc_k;
        logic    clr_k;
        logic    inc_work;
        logic    load_out;
    } cmd_t;

    typedef struct packed
    {
        logic in_barrier;
        logic in_src_empty;
        logic a_sel;
        logic b_sel;
        logic a_last;
        logic b_last;
        logic k_last;
        logic out_free;
    } status_t;

    function automatic entry_idx_t entry_of(input stage_idx_t row, input stage_idx_t col);
        return entry_idx_t'(int'(row) * NUM_STAGES + int'(col));
    endfunction

    function automatic logic lane_ok(input stage_idx_t idx);
        return (int'(idx) < MASK_BITS);
    endfunction

    function automatic logic mask_bit(input mask_t m, input stage_idx_t idx);
        logic r;
        r = 1'b0;
        if (lane_ok(idx))
        begin
            r = m[idx[MASK_IDX_BITS-1:0]];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/stage_dependency_bubble_tracker.sv =====
// top level of the stage dependency bubble tracker
// depends on sdbt_pkg, sdbt_ctrl, sdbt_dp (and sdbt_ram below it)
//
// Tracks work items for four pipeline stages (compute, geometry, fragment,
// transfer) and the barriers between them, and returns one result item per
// input item. A work item (operation 0) checks every other stage for a
// bubble against the target stage, then bumps the target's saturating work
// count; bubble_mask/bubble_found carry the stages that block it. A barrier
// (operation 1) merges wait indices of the source stages into each
// destination stage and latches counts; its result is always zero. One
// item is processed at a time. The dependency table (wait index and latched
// count per stage pair) sits in a single-port-read ram with a registered
// read, so each table lookup takes a sequencer state of its own.
// A finished result sits in an output register, so the next item can be
// accepted while it waits for out_ready. Reset clears the control state
// (work counts, indices, result mask, output valid, table valid bits) but
// not the payload registers or the ram; no clearing pass is needed since
// the table uses per-entry valid bits.
`default_nettype none

module stage_dependency_bubble_tracker
    import sdbt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  operation,
    input  wire logic [STAGE_BITS-1:0] stage,
    input  wire logic [MASK_BITS-1:0]  src_mask,
    input  wire logic [MASK_BITS-1:0]  dst_mask,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [MASK_BITS-1:0]       bubble_mask,
    output logic                       bubble_found
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t stat;

    sdbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdbt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .stage        (stage),
        .src_mask     (src_mask),
        .dst_mask     (dst_mask),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bubble_mask  (bubble_mask),
        .bubble_found (bubble_found)
    );

endmodule

`default_nettype wire

// ===== src/sdbt_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module sdbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/sdbt_ctrl.sv =====
// sequencer of the tracker: walks work checks and barrier merges
// depends on sdbt_pkg
`default_nettype none

module sdbt_ctrl
    import sdbt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (!stat.in_barrier) state_next = ST_SUB_INIT;
                    else if (stat.in_src_empty)    state_next = ST_DONE;
                    else                           state_next = ST_BAR_DST;
                end
            end
            ST_SUB_INIT:   state_next = ST_SUB_RD_FWD;
            ST_SUB_RD_FWD: state_next = ST_SUB_RD_REV;
            ST_SUB_RD_REV: state_next = ST_SUB_EVAL;
            ST_SUB_EVAL:   state_next = stat.b_last ? ST_SUB_INC : ST_SUB_RD_FWD;
            ST_SUB_INC:    state_next = ST_DONE;
            ST_BAR_DST:
            begin
                priority if (stat.a_sel) state_next = ST_BAR_SRC;
                else if (stat.a_last)    state_next = ST_DONE;
                else                     state_next = ST_BAR_DST;
            end
            ST_BAR_SRC:
            begin
                priority if (stat.b_sel) state_next = ST_BAR_OWN_RD;
                else if (!stat.b_last)   state_next = ST_BAR_SRC;
                else if (stat.a_last)    state_next = ST_DONE;
                else                     state_next = ST_BAR_DST;
            end
            ST_BAR_OWN_RD:   state_next = ST_BAR_OWN_WR;
            ST_BAR_OWN_WR:   state_next = ST_BAR_K_RD_SRC;
            ST_BAR_K_RD_SRC: state_next = ST_BAR_K_RD_DST;
            ST_BAR_K_RD_DST: state_next = ST_BAR_K_WR;
            ST_BAR_K_WR:
            begin
                priority if (!stat.k_last) state_next = ST_BAR_K_RD_SRC;
                else if (!stat.b_last)     state_next = ST_BAR_SRC;
                else if (stat.a_last)      state_next = ST_DONE;
                else                       state_next = ST_BAR_DST;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_AB;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_SUB_INIT:
            begin
                cmd.cap_dst = 1'b1;
            end
            ST_SUB_RD_FWD:
            begin
                cmd.rd_sel  = RD_AB;
                cmd.cap_oth = 1'b1;
            end
            ST_SUB_RD_REV:
            begin
                cmd.rd_sel   = RD_BA;
                cmd.cond_chk = 1'b1;
            end
            ST_SUB_EVAL:
            begin
                cmd.mask_chk = 1'b1;
                cmd.inc_b    = !stat.b_last;
            end
            ST_SUB_INC:
            begin
                cmd.inc_work = 1'b1;
            end
            ST_BAR_DST:
            begin
                cmd.cap_dst = stat.a_sel;
                cmd.clr_b   = stat.a_sel;
                cmd.inc_a   = !stat.a_sel && !stat.a_last;
            end
            ST_BAR_SRC:
            begin
                cmd.inc_b = !stat.b_sel && !stat.b_last;
                cmd.inc_a = !stat.b_sel && stat.b_last && !stat.a_last;
            end
            ST_BAR_OWN_RD:
            begin
                cmd.rd_sel  = RD_AB;
                cmd.cap_oth = 1'b1;
            end
            ST_BAR_OWN_WR:
            begin
                cmd.wr_own = 1'b1;
                cmd.clr_k  = 1'b1;
            end
            ST_BAR_K_RD_SRC:
            begin
                cmd.rd_sel = RD_BK;
            end
            ST_BAR_K_RD_DST:
            begin
                cmd.rd_sel  = RD_AK;
                cmd.cap_src = 1'b1;
            end
            ST_BAR_K_WR:
            begin
                cmd.wr_inh = 1'b1;
                cmd.inc_k  = !stat.k_last;
                cmd.inc_b  = stat.k_last && !stat.b_last;
                cmd.inc_a  = stat.k_last && stat.b_last && !stat.a_last;
            end
            ST_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sdbt_dp.sv =====
// datapath of the tracker: work counts, dependency table, compares and result register
// depends on sdbt_pkg and sdbt_ram
`default_nettype none

module sdbt_dp
    import sdbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       operation,
    input  wire stage_idx_t stage,
    input  wire mask_t      src_mask,
    input  wire mask_t      dst_mask,
    input  wire cmd_t       cmd,
    output status_t         stat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mask_t           bubble_mask,
    output logic            bubble_found
);

    count_t     work_count_reg [NUM_STAGES];
    logic [ENTRIES-1:0] entry_valid_reg;
    stage_idx_t idx_a_reg;
    stage_idx_t idx_b_reg;
    stage_idx_t idx_k_reg;
    mask_t      src_mask_reg;
    mask_t      dst_mask_reg;
    mask_t      mask_reg;
    mask_t      out_mask_reg;
    logic       out_valid_reg;
    logic       rd_valid_reg;
    logic       cond_reg;
    count_t     wc_dst_reg;
    count_t     wc_oth_reg;
    count_t     src_wait_reg;

    entry_idx_t           rd_addr;
    entry_idx_t           wr_addr;
    logic                 wr_en;
    logic [PAIR_BITS-1:0] wr_data;
    logic [PAIR_BITS-1:0] rd_data;
    count_t               rd_wait;
    count_t               rd_latched;
    logic                 pair_excluded;

    // table entry: wait index in the upper half, latched own count in the lower
    sdbt_ram #(
        .WIDTH (PAIR_BITS),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_AB: rd_addr = entry_of(idx_a_reg, idx_b_reg);
            RD_BA: rd_addr = entry_of(idx_b_reg, idx_a_reg);
            RD_BK: rd_addr = entry_of(idx_b_reg, idx_k_reg);
            RD_AK: rd_addr = entry_of(idx_a_reg, idx_k_reg);
            default: rd_addr = entry_of(idx_a_reg, idx_b_reg);
        endcase
    end

    // never-written entries read as zero
    assign rd_wait    = rd_valid_reg ? rd_data[PAIR_BITS-1:COUNT_BITS] : '0;
    assign rd_latched = rd_valid_reg ? rd_data[COUNT_BITS-1:0] : '0;

    assign wr_en   = (cmd.wr_own && (wc_oth_reg > rd_wait))
                  || (cmd.wr_inh && (src_wait_reg > rd_wait));
    assign wr_addr = cmd.wr_own ? entry_of(idx_a_reg, idx_b_reg)
                                : entry_of(idx_a_reg, idx_k_reg);
    assign wr_data = {(cmd.wr_own ? wc_oth_reg : src_wait_reg), wc_dst_reg};

    assign pair_excluded = ((idx_b_reg == STAGE_COMPUTE) && (idx_a_reg == STAGE_GEOMETRY))
                        || ((idx_b_reg == STAGE_GEOMETRY) && (idx_a_reg == STAGE_COMPUTE));

    always_comb
    begin
        stat.in_barrier   = (op_t'(operation) == OP_BARRIER);
        stat.in_src_empty = (src_mask == '0);
        stat.a_sel        = mask_bit(dst_mask_reg, idx_a_reg);
        stat.b_sel        = mask_bit(src_mask_reg, idx_b_reg);
        stat.a_last       = (idx_a_reg == STAGE_LAST);
        stat.b_last       = (idx_b_reg == STAGE_LAST);
        stat.k_last       = (idx_k_reg == STAGE_LAST);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                work_count_reg[s] <= '0;
            end
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            idx_a_reg       <= '0;
            idx_b_reg       <= '0;
            idx_k_reg       <= '0;
            mask_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= entry_valid_reg[rd_addr];
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.load_item)
            begin
                idx_a_reg <= (op_t'(operation) == OP_WORK) ? stage : '0;
                idx_b_reg <= '0;
                mask_reg  <= '0;
            end
            if (cmd.inc_a)
            begin
                idx_a_reg <= idx_a_reg + 1'b1;
            end
            if (cmd.clr_b)
            begin
                idx_b_reg <= '0;
            end
            if (cmd.inc_b)
            begin
                idx_b_reg <= idx_b_reg + 1'b1;
            end
            if (cmd.clr_k)
            begin
                idx_k_reg <= '0;
            end
            if (cmd.inc_k)
            begin
                idx_k_reg <= idx_k_reg + 1'b1;
            end
            if (cmd.mask_chk && cond_reg && (rd_wait == wc_dst_reg)
                && (wc_oth_reg != rd_latched) && lane_ok(idx_b_reg))
            begin
                mask_reg[idx_b_reg[MASK_IDX_BITS-1:0]] <= 1'b1;
            end
            if (cmd.inc_work && (wc_dst_reg != COUNT_MAX))
            begin
                work_count_reg[idx_a_reg] <= wc_dst_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            src_mask_reg <= src_mask;
            dst_mask_reg <= dst_mask;
        end
        if (cmd.cap_dst)
        begin
            wc_dst_reg <= work_count_reg[idx_a_reg];
        end
        if (cmd.cap_oth)
        begin
            wc_oth_reg <= work_count_reg[idx_b_reg];
        end
        if (cmd.cap_src)
        begin
            src_wait_reg <= rd_wait;
        end
        if (cmd.cond_chk)
        begin
            cond_reg <= (idx_b_reg != idx_a_reg) && (rd_wait == wc_oth_reg)
                     && (wc_dst_reg != '0) && !pair_excluded;
        end
        if (cmd.load_out)
        begin
            out_mask_reg <= mask_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bubble_mask  = out_mask_reg;
    assign bubble_found = (out_mask_reg != '0);

endmodule

`default_nettype wire

// ===== src/sdbt_checker.sv =====
// port-level checks of the stage dependency bubble tracker, bound to the top level
// depends on sdbt_pkg and stage_dependency_bubble_tracker
`default_nettype none

module sdbt_checker
    import sdbt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  operation,
    input wire logic [STAGE_BITS-1:0] stage,
    input wire logic [MASK_BITS-1:0]  src_mask,
    input wire logic [MASK_BITS-1:0]  dst_mask,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [MASK_BITS-1:0]  bubble_mask,
    input wire logic                  bubble_found
);

    // a result not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bubble_mask))
        else $error("result changed while stalled");

    a_found_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bubble_found == (bubble_mask != '0)))
        else $error("bubble_found disagrees with bubble_mask");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in flight");

    // a fresh result frees the input side
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not ready after result was posted");

endmodule

bind stage_dependency_bubble_tracker sdbt_checker u_sdbt_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for stage_dependency_bubble_tracker
// depends on sdbt_pkg and the tracker rtl; holds its own model of the bubble rules
module testbench
    import sdbt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 6;
    // limit sits well above the slowest barrier and the long output hold; leave a wide margin
    localparam int STUCK_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed
    {
        mask_t mask;
        logic  found;
    } bubble_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       operation = OP_WORK;
    stage_idx_t stage = '0;
    mask_t      src_mask = '0;
    mask_t      dst_mask = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    mask_t      bubble_mask;
    logic       bubble_found;

    // model state: work counts, wait indices and latched counts per stage pair
    count_t work_cnt [NUM_STAGES] = '{default: '0};
    count_t wait_on [NUM_STAGES][NUM_STAGES] = '{default: '{default: '0}};
    count_t latch_at [NUM_STAGES][NUM_STAGES] = '{default: '{default: '0}};

    bubble_result_t expected_bubbles [$];

    int   error_count = 0;
    int   items_sent = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   stuck_cycles = 0;
    int   stall_left = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;

    stage_dependency_bubble_tracker dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .stage        (stage),
        .src_mask     (src_mask),
        .dst_mask     (dst_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bubble_mask  (bubble_mask),
        .bubble_found (bubble_found)
    );

    always #5 clk = ~clk;

    // work item on stage dst: collect blocking stages, then bump the saturating count
    function automatic mask_t bubbles_for_work(input stage_idx_t dst);
        mask_t m;
        int    i;
        m = '0;
        for (i = 0; i < NUM_STAGES; i++)
        begin
            if (i == int'(dst))
                continue;
            if (wait_on[dst][i] != work_cnt[i])
                continue;
            if (work_cnt[dst] == '0)
                continue;
            // compute and geometry never block each other
            if ((stage_idx_t'(i) == STAGE_COMPUTE && dst == STAGE_GEOMETRY) ||
                (stage_idx_t'(i) == STAGE_GEOMETRY && dst == STAGE_COMPUTE))
                continue;
            if (i < MASK_BITS && wait_on[i][dst] == work_cnt[dst] &&
                work_cnt[i] != latch_at[i][dst])
                m[i] = 1'b1;
        end
        if (work_cnt[dst] != COUNT_MAX)
            work_cnt[dst] = work_cnt[dst] + 1'b1;
        return m;
    endfunction

    // barrier: merge source rows into each destination row, ascending order
    function automatic void apply_barrier(input mask_t srcm, input mask_t dstm);
        int d;
        int s;
        int k;
        if (srcm == '0)
            return;
        for (d = 0; d < NUM_STAGES; d++)
        begin
            if (d >= MASK_BITS || !dstm[d])
                continue;
            for (s = 0; s < NUM_STAGES; s++)
            begin
                if (s >= MASK_BITS || !srcm[s])
                    continue;
                if (work_cnt[s] > wait_on[d][s])
                begin
                    wait_on[d][s] = work_cnt[s];
                    latch_at[d][s] = work_cnt[d];
                end
                for (k = 0; k < NUM_STAGES; k++)
                begin
                    if (wait_on[s][k] > wait_on[d][k])
                    begin
                        wait_on[d][k] = wait_on[s][k];
                        latch_at[d][k] = work_cnt[d];
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 100)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // offer one item, hold it until accepted, then record the predicted result
    task automatic send_item(input op_t op, input stage_idx_t st, input mask_t srcm,
                             input mask_t dstm);
        bubble_result_t res;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        stage <= st;
        src_mask <= srcm;
        dst_mask <= dstm;
        do
            @(posedge clk);
        while (!in_ready);
        res.mask = '0;
        if (op == OP_WORK)
            res.mask = bubbles_for_work(st);
        else
            apply_barrier(srcm, dstm);
        res.found = |res.mask;
        expected_bubbles.push_back(res);
        items_sent++;
    endtask

    task automatic send_work(input stage_idx_t st);
        send_item(OP_WORK, st, mask_t'($urandom_range(15)), mask_t'($urandom_range(15)));
    endtask

    task automatic send_barrier(input mask_t srcm, input mask_t dstm);
        send_item(OP_BARRIER, stage_idx_t'($urandom_range(3)), srcm, dstm);
    endtask

    // mostly the pattern that leads to a bubble between two stages, with random
    // counts and extra bits; some plain noise and some sequences with a step missing
    task automatic run_sequence();
        stage_idx_t d;
        stage_idx_t i;
        int         kind;
        mask_t      extra;
        d = stage_idx_t'($urandom_range(3));
        i = stage_idx_t'($urandom_range(3));
        while (i == d)
            i = stage_idx_t'($urandom_range(3));
        kind = $urandom_range(9);
        extra = ($urandom_range(3) == 0) ? mask_t'($urandom_range(15)) : '0;
        if (kind < 7)
        begin
            repeat ($urandom_range(1, 2)) send_work(d);
            repeat ($urandom_range(1, 2)) send_work(i);
            send_barrier(mask_t'(1 << i) | extra, mask_t'(1 << d));
            send_barrier(mask_t'(1 << d), mask_t'(1 << i) | extra);
            repeat ($urandom_range(0, 2)) send_work(i);
            send_work(d);
        end
        else if (kind < 9)
        begin
            repeat ($urandom_range(1, 4))
                send_item(op_t'($urandom_range(1)), stage_idx_t'($urandom_range(3)),
                          mask_t'($urandom_range(15)), mask_t'($urandom_range(15)));
        end
        else
        begin
            send_work(d);
            send_barrier(mask_t'(1 << d), mask_t'(1 << i));
            send_work(i);
            send_work(d);
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // barrier with no source stages leaves everything alone
        send_item(OP_BARRIER, 2'd3, 4'b0000, 4'b1111);
        // first work on every stage, no bubble possible yet
        send_item(OP_WORK, STAGE_COMPUTE, 4'b1111, 4'b0000);
        send_item(OP_WORK, STAGE_GEOMETRY, 4'b0000, 4'b1111);
        send_item(OP_WORK, 2'd2, 4'b1010, 4'b0101);
        send_item(OP_WORK, STAGE_LAST, 4'b0101, 4'b1010);
        // everything waits on everything
        send_item(OP_BARRIER, 2'd0, 4'b1111, 4'b1111);
        // stage merged into itself only raises its own index
        send_item(OP_BARRIER, 2'd1, 4'b0100, 4'b0100);
        // fragment gets new work, transfer then waits on it: bubble on transfer
        send_item(OP_WORK, 2'd2, 4'b0000, 4'b0000);
        send_item(OP_BARRIER, 2'd2, 4'b0100, 4'b1000);
        send_item(OP_WORK, STAGE_LAST, 4'b1111, 4'b1111);
        // same shape between compute and geometry, which never block each other
        send_item(OP_BARRIER, 2'd3, 4'b0011, 4'b0011);
        send_item(OP_WORK, STAGE_GEOMETRY, 4'b0000, 4'b0000);
        send_item(OP_BARRIER, 2'd0, 4'b0010, 4'b0001);
        send_item(OP_WORK, STAGE_COMPUTE, 4'b0000, 4'b0000);
        // compute against fragment does count
        send_item(OP_BARRIER, 2'd1, 4'b0101, 4'b0101);
        send_item(OP_WORK, 2'd2, 4'b0000, 4'b0000);
        send_item(OP_BARRIER, 2'd0, 4'b0100, 4'b0001);
        send_item(OP_WORK, STAGE_COMPUTE, 4'b1111, 4'b0000);
        // sources without destinations, and the widest barrier once more
        send_item(OP_BARRIER, 2'd3, 4'b1111, 4'b0000);
        send_item(OP_BARRIER, 2'd3, 4'b1111, 4'b1111);
        send_item(OP_WORK, STAGE_LAST, 4'b0000, 4'b1111);
    endtask

    task automatic test_random_traffic(input int n, input int send_idle, input int recv_stall);
        int stop_at;
        idle_pct = send_idle;
        stall_pct = recv_stall;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
            run_sequence();
    endtask

    // receiver holds off for a long stretch while items keep coming, so the
    // output register fills and the block stops taking input
    task automatic test_output_hold();
        int stop_at;
        idle_pct = 0;
        stall_pct = 0;
        hold_toggle <= ~hold_toggle;
        stop_at = items_sent + 40;
        while (items_sent < stop_at)
            run_sequence();
    endtask

    // receiver: random stalls, plus the long hold when requested
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            stall_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result check against the oldest prediction
    always @(posedge clk)
    begin
        bubble_result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_bubbles.size() == 0)
            begin
                report_mismatch("unexpected result, bubble_mask", bubble_mask, 0);
            end
            else
            begin
                want = expected_bubbles.pop_front();
                if (bubble_mask !== want.mask)
                    report_mismatch("bubble_mask", bubble_mask, want.mask);
                if (bubble_found !== want.found)
                    report_mismatch("bubble_found", bubble_found, want.found);
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 64, 0);
        test_random_traffic(220, 0, 64);
        test_random_traffic(220, 13, 13);
        test_output_hold();

        in_valid <= 1'b0;
        while (expected_bubbles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
